>>> rtl/bsp_pkg.sv
// Types and constants shared by the base address register sizing block.
package bsp_pkg;

    localparam int ADDR_W = 64;

    // Register indexes on the configuration port (byte address = 8 * index)
    localparam logic [1:0] REG_WINDOW_ENABLE = 2'd0;
    localparam logic [1:0] REG_WINDOW_BASE   = 2'd1;
    localparam logic [1:0] REG_WINDOW_LIMIT  = 2'd2;

    // Flag bits cleared from the readback: I/O and memory forms
    localparam logic [ADDR_W-1:0] IO_FLAG_MASK  = ~64'h3;
    localparam logic [ADDR_W-1:0] MEM_FLAG_MASK = ~64'hF;
    localparam logic [1:0]        MEM_TYPE_64   = 2'd2;

    typedef struct packed {
        logic              impl;
        logic              io;
        logic              wide;
        logic              want;   // memory region at address zero
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] sm1;    // size - 1
    } t_dec;

    typedef struct packed {
        logic              impl;
        logic              io;
        logic              wide;
        logic              placed;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
    } t_res;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] limit;
    } t_win;

endpackage

>>> rtl/bsp_decode.sv
// Decode of one probe: region type, size and the address found in the register.
module bsp_decode (
    input  logic [31:0]   i_original_low,
    input  logic [31:0]   i_original_high,
    input  logic [31:0]   i_probe_low,
    input  logic [31:0]   i_probe_high,
    output bsp_pkg::t_dec o_dec
);
    import bsp_pkg::*;

    logic              io;
    logic              wide;
    logic [ADDR_W-1:0] mask;
    logic              impl;
    logic [ADDR_W-1:0] addr;

    always_comb begin
        io   = i_original_low[0];
        wide = !io && (i_original_low[2:1] == MEM_TYPE_64);
        mask = {(wide ? i_probe_high : 32'hFFFF_FFFF), i_probe_low}
             & (i_probe_low[0] ? IO_FLAG_MASK : MEM_FLAG_MASK);
        impl = (mask != '0);
        if (!impl) begin
            addr = '0;
        end else if (io) begin
            addr = {32'd0, i_original_low} & IO_FLAG_MASK;
        end else begin
            addr = {(wide ? i_original_high : 32'd0), i_original_low} & MEM_FLAG_MASK;
        end
        o_dec.impl = impl;
        o_dec.io   = io;
        o_dec.wide = wide;
        o_dec.want = impl && !io && (addr == '0);
        o_dec.addr = addr;
        o_dec.size = impl ? (~mask + 64'd1) : '0;
        o_dec.sm1  = impl ? ~mask : '0;
    end

endmodule

>>> rtl/bsp_place.sv
// Window placement of unassigned memory regions and the running free pointer.
module bsp_place (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bsp_pkg::t_dec              i_dec,
    input  bsp_pkg::t_win              i_win,
    input  logic                       i_base_load,
    input  logic [bsp_pkg::ADDR_W-1:0] i_base_value,
    input  logic                       i_step,
    output bsp_pkg::t_res              o_res
);
    import bsp_pkg::*;

    logic [ADDR_W-1:0] r_next_free;
    logic [ADDR_W-1:0] n_next_free;
    logic [ADDR_W:0]   up_sum;
    logic [ADDR_W-1:0] aligned;
    logic [ADDR_W:0]   end_sum;
    logic              fit;
    logic              do_place;

    always_comb begin
        up_sum   = {1'b0, r_next_free} + {1'b0, i_dec.sm1};
        aligned  = up_sum[ADDR_W-1:0] & ~i_dec.sm1;
        end_sum  = {1'b0, aligned} + {1'b0, i_dec.size};
        fit      = !up_sum[ADDR_W] && !end_sum[ADDR_W]
                && (end_sum[ADDR_W-1:0] <= i_win.limit);
        do_place = i_dec.want && i_win.en && fit;

        o_res.impl   = i_dec.impl;
        o_res.io     = i_dec.io;
        o_res.wide   = i_dec.wide;
        o_res.placed = do_place;
        o_res.addr   = do_place ? aligned : i_dec.addr;
        o_res.size   = i_dec.size;

        n_next_free = r_next_free;
        if (i_base_load) begin
            n_next_free = i_base_value;
        end else if (i_step && do_place) begin
            n_next_free = end_sum[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
        end else begin
            r_next_free <= n_next_free;
        end
    end

endmodule

>>> rtl/bar_size_and_place.sv
// Base address register sizing and placement: one probe in, one decoded region out per cycle, if not stalled.
// Each transaction on the input stream is one probe of a base address register; the block
// returns its type, size and address, placing memory regions found at address zero into the
// configured window at the next size-aligned address. Items go through a three-stage pipeline
// (input register, decode register, result register) and one item is accepted every cycle
// while the output is not stalled. The free pointer advances in the placement stage, so
// placements follow the order of the items.
// Registers (64-bit APB, byte address 8*index): window_enable at 0x00, window_base at 0x08
// (a write also reloads the free pointer), window_limit at 0x10. Write only while idle.
module bar_size_and_place (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] original_low, [63:32] original_high, [95:64] probe_low, [127:96] probe_high
    input  logic [127:0] s_axis_tdata,
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] implemented, [64:1] base_address, [128:65] region_size, [129] placed, rest zero
    output logic [135:0] m_axis_tdata,
    // [0] is_io, [1] is_wide
    output logic [1:0]   m_axis_tuser
);
    import bsp_pkg::*;

    // configuration
    logic              r_win_en;
    logic [ADDR_W-1:0] r_win_base;
    logic [ADDR_W-1:0] r_win_limit;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;

    // pipeline
    logic              r_v0, r_v1, r_v2;
    logic [127:0]      r_in;
    t_dec              r_dec;
    t_res              r_res;
    t_dec              dec;
    t_res              res;
    t_win              win;
    logic              en0, en1, en2;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:3];

    always_comb begin
        case (cfg_idx)
            REG_WINDOW_ENABLE: prdata = {63'd0, r_win_en};
            REG_WINDOW_BASE:   prdata = r_win_base;
            REG_WINDOW_LIMIT:  prdata = r_win_limit;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_en    <= 1'b0;
            r_win_base  <= '0;
            r_win_limit <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WINDOW_ENABLE: r_win_en    <= pwdata[0];
                REG_WINDOW_BASE:   r_win_base  <= pwdata;
                REG_WINDOW_LIMIT:  r_win_limit <= pwdata;
                default:           ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    assign en2 = !r_v2 || m_axis_tready;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;
    assign s_axis_tready = en0;

    bsp_decode u_decode (
        .i_original_low  (r_in[31:0]),
        .i_original_high (r_in[63:32]),
        .i_probe_low     (r_in[95:64]),
        .i_probe_high    (r_in[127:96]),
        .o_dec           (dec)
    );

    assign win.en    = r_win_en;
    assign win.limit = r_win_limit;

    bsp_place u_place (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dec        (r_dec),
        .i_win        (win),
        .i_base_load  (cfg_wr && (cfg_idx == REG_WINDOW_BASE)),
        .i_base_value (pwdata),
        .i_step       (r_v1 && en2),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en0) r_v0 <= s_axis_tvalid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) r_in  <= s_axis_tdata;
        if (en1) r_dec <= dec;
        if (en2) r_res <= res;
    end

    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = {6'd0, r_res.placed, r_res.size, r_res.addr, r_res.impl};
    assign m_axis_tuser  = {r_res.wide, r_res.io};

`ifndef SYNTHESIS
    a_placed_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_res.placed |-> r_res.impl && !r_res.io && r_win_en)
        else $error("placed region is not an implemented memory region");

    a_unimpl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r_res.impl |-> r_res.size == '0 && r_res.addr == '0 && !r_res.placed)
        else $error("unimplemented register carries size or address");

    a_io_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_res.io |-> !r_res.wide && !r_res.placed)
        else $error("I/O region flagged wide or placed");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_v0 && r_v1 && r_v2 && !m_axis_tready)
        else $error("input stalled while pipeline has room");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for bar_size_and_place: directed table, then random probe traffic.
module tb_top;
    import bsp_pkg::*;

    localparam int QUIET_LIMIT = 4000;   // cycles with no transaction before giving up
    localparam int PHASE_ITEMS = 160;
    localparam int REPROGRAM_EVERY = 40;

    typedef enum logic { ROW_PROBE, ROW_WRITE } t_row_kind;

    typedef struct {
        t_row_kind    kind;
        logic [127:0] probe;    // {probe_high, probe_low, original_high, original_low}
        bit           typed;    // want holds a hand-computed expectation
        t_res         want;
        logic [1:0]   reg_idx;
        logic [63:0]  reg_val;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    // hand-computed expectation travelling alongside the probe being offered
    bit           known_valid = 1'b0;
    t_res         known_region = '0;

    // shadow of the block's registers and free pointer
    logic         win_en = 1'b0;
    logic [63:0]  win_limit = '0;
    logic [63:0]  free_ptr = '0;

    t_res         pending_regions[$];
    int           mismatch_count = 0;
    int           quiet_cycles = 0;
    int           tx_gap_pct = 21;
    int           rx_stall_pct = 56;
    t_row         directed_rows[$];

    bar_size_and_place i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic t_res region(input logic impl, input logic io, input logic wide,
                                    input logic placed, input logic [63:0] addr,
                                    input logic [63:0] size);
        t_res r;
        r.impl = impl;
        r.io = io;
        r.wide = wide;
        r.placed = placed;
        r.addr = addr;
        r.size = size;
        return r;
    endfunction

    // Decode one probe and, for an unplaced memory region, take space from the window.
    function automatic t_res place_region(input logic [127:0] probe);
        logic [31:0] olo, ohi, plo, phi;
        logic [63:0] rb, sm1, aligned;
        logic [64:0] reach, top;
        t_res        r;
        {phi, plo, ohi, olo} = probe;
        r = '0;
        r.io = olo[0];
        r.wide = !olo[0] && (olo[2:1] == MEM_TYPE_64);
        // narrow registers read back all ones above bit 31
        rb = {r.wide ? phi : 32'hFFFF_FFFF, plo} & (plo[0] ? IO_FLAG_MASK : MEM_FLAG_MASK);
        if (rb != '0) begin
            r.impl = 1'b1;
            r.size = ~rb + 64'd1;
            if (r.io) begin
                r.addr = {32'h0, olo} & IO_FLAG_MASK;
            end else begin
                r.addr = {r.wide ? ohi : 32'h0, olo} & MEM_FLAG_MASK;
                if (r.addr == '0 && win_en) begin
                    sm1 = r.size - 64'd1;
                    reach = {1'b0, free_ptr} + {1'b0, sm1};
                    aligned = reach[63:0] & ~sm1;
                    top = {1'b0, aligned} + {1'b0, r.size};
                    if (!reach[64] && !top[64] && top[63:0] <= win_limit) begin
                        r.addr = aligned;
                        r.placed = 1'b1;
                        free_ptr = top[63:0];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_row probe_row(input logic [31:0] olo, input logic [31:0] ohi,
                                       input logic [31:0] plo, input logic [31:0] phi);
        t_row row;
        row.kind = ROW_PROBE;
        row.probe = {phi, plo, ohi, olo};
        row.typed = 1'b0;
        row.want = '0;
        row.reg_idx = REG_WINDOW_ENABLE;
        row.reg_val = '0;
        return row;
    endfunction

    function automatic t_row known_row(input logic [31:0] olo, input logic [31:0] ohi,
                                       input logic [31:0] plo, input logic [31:0] phi,
                                       input t_res want);
        t_row row;
        row = probe_row(olo, ohi, plo, phi);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic t_row write_row(input logic [1:0] idx, input logic [63:0] val);
        t_row row;
        row = probe_row('0, '0, '0, '0);
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // Mostly well-formed probes (readback = ~(size-1) with the register's flags), some noise.
    function automatic logic [127:0] random_probe();
        int          pick;
        int          k;
        logic        wide;
        logic [1:0]  mtype;
        logic [3:0]  flags;
        logic [63:0] size, addr, rb;
        logic [31:0] olo, ohi, plo, phi;
        pick = $urandom_range(99);
        ohi = $urandom;
        phi = $urandom;
        if (pick < 15) begin
            olo = $urandom;
            plo = $urandom;
        end else if (pick < 35) begin
            k = $urandom_range(2, 16);
            olo = ($urandom_range(1) == 0) ? 32'h1 : (($urandom << k) | 32'h1);
            plo = (32'hFFFF_FFFF << k) | 32'h1;
        end else if (pick < 40) begin
            // 64-bit register that reads back nothing
            olo = ($urandom & 32'hFFFF_FFF8) | 32'h4;
            plo = $urandom & 32'hE;
            phi = '0;
        end else begin
            wide = ($urandom_range(99) < 55);
            case ($urandom_range(5))
                0: mtype = 2'd1;
                1: mtype = 2'd3;
                default: mtype = 2'd0;
            endcase
            if (wide) mtype = MEM_TYPE_64;
            flags = {1'($urandom_range(1)), mtype, 1'b0};
            k = ($urandom_range(9) == 0) ? $urandom_range(17, wide ? 63 : 32)
                                         : $urandom_range(4, 16);
            size = 64'h1 << k;
            addr = ($urandom_range(1) == 0) ? 64'h0 : ({$urandom, $urandom} & ~(size - 64'd1));
            rb = ~(size - 64'd1);
            olo = addr[31:0] | {28'h0, flags};
            plo = rb[31:0] | {28'h0, flags};
            if (wide) begin
                ohi = addr[63:32];
                phi = rb[63:32];
            end
        end
        return {phi, plo, ohi, olo};
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic write_window_reg(input logic [1:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WINDOW_ENABLE: win_en = val[0];
            REG_WINDOW_BASE:   free_ptr = val;   // base write reloads the free pointer
            REG_WINDOW_LIMIT:  win_limit = val;
            default: ;
        endcase
        // idle gap so a following write starts on a later edge
        @(posedge i_clk);
    endtask

    task automatic send_probe(input logic [127:0] probe, input bit typed, input t_res want);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= probe;
        known_valid <= typed;
        known_region <= want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);   // let the monitor log the last accepted probe
        while (pending_regions.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = region(m_axis_tdata[0], m_axis_tuser[0], m_axis_tuser[1],
                             m_axis_tdata[129], m_axis_tdata[64:1], m_axis_tdata[128:65]);
                if (pending_regions.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    mismatch_count++;
                end else begin
                    t_res want;
                    want = pending_regions.pop_front();
                    check_field("implemented", 64'(want.impl), 64'(got.impl));
                    check_field("is_io", 64'(want.io), 64'(got.io));
                    check_field("is_wide", 64'(want.wide), 64'(got.wide));
                    check_field("base_address", want.addr, got.addr);
                    check_field("region_size", want.size, got.size);
                    check_field("placed", 64'(want.placed), 64'(got.placed));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                got = place_region(s_axis_tdata);
                pending_regions.push_back(known_valid ? known_region : got);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (psel && penable && pwrite && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        logic [63:0] base, lim;
        directed_rows = '{
            // reset state: window off, nothing is placed
            known_row(32'h0, 32'h0, 32'h0, 32'h0,
                      region(1, 0, 0, 0, 64'h0, 64'h1_0000_0000)),
            known_row(32'h4, 32'h0, 32'h0, 32'h0, region(0, 0, 1, 0, 64'h0, 64'h0)),
            known_row(32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hC, 32'h0,
                      region(0, 0, 1, 0, 64'h0, 64'h0)),
            known_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'h0,
                      region(1, 1, 0, 0, 64'hFFFF_FFFC, 64'h4)),
            probe_row(32'h1234_5679, 32'h0, 32'hFFFF_FF01, 32'hDEAD_BEEF),
            known_row(32'hFEDC_B008, 32'h0BAD_F00D, 32'hFFFF_F008, 32'h0,
                      region(1, 0, 0, 0, 64'hFEDC_B000, 64'h1000)),
            known_row(32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFF,
                      region(1, 0, 1, 0, 64'hFFFF_FFFF_FFFF_FFF0, 64'h10)),
            known_row(32'h4, 32'h0, 32'h4, 32'h8000_0000,
                      region(1, 0, 1, 0, 64'h0, 64'h8000_0000_0000_0000)),
            probe_row(32'h2, 32'h0, 32'hFFF0_0002, 32'h0),
            probe_row(32'h0010_0006, 32'h0, 32'hFFF0_0006, 32'h1234_5678),
            probe_row(32'h0, 32'h0, 32'hFFFF_FFF1, 32'h0),          // memory readback, bit 0 set
            probe_row(32'h4, 32'h0, 32'hFFFF_0F00, 32'hFFFF_FFFF),  // size not a power of two
            // small window, filled up to its exact end
            write_row(REG_WINDOW_ENABLE, 64'h1),
            write_row(REG_WINDOW_BASE, 64'h1000),
            write_row(REG_WINDOW_LIMIT, 64'h1_0000),
            known_row(32'h0, 32'h0, 32'hFFFF_F000, 32'h0,
                      region(1, 0, 0, 1, 64'h1000, 64'h1000)),
            probe_row(32'h0, 32'h0, 32'hFFFF_FF00, 32'h0),
            probe_row(32'h4, 32'h0, 32'hFFFF_C004, 32'hFFFF_FFFF),
            probe_row(32'h8, 32'h0, 32'hFFFF_8008, 32'h0),
            known_row(32'h0, 32'h0, 32'hFFFF_FFF0, 32'h0, region(1, 0, 0, 0, 64'h0, 64'h10)),
            probe_row(32'h2000, 32'h0, 32'hFFFF_F000, 32'h0),
            known_row(32'h1, 32'h0, 32'hFFFF_FF01, 32'h0, region(1, 1, 0, 0, 64'h0, 64'h100)),
            // window at the top of the address space: end-of-range carries
            write_row(REG_WINDOW_BASE, 64'hFFFF_FFFF_FFFF_F000),
            write_row(REG_WINDOW_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF),
            known_row(32'h4, 32'h0, 32'hFFFF_F004, 32'hFFFF_FFFF,
                      region(1, 0, 1, 0, 64'h0, 64'h1000)),
            probe_row(32'h4, 32'h0, 32'hFFFF_F804, 32'hFFFF_FFFF),
            known_row(32'h4, 32'h0, 32'hFFFF_F004, 32'hFFFF_FFFF,
                      region(1, 0, 1, 0, 64'h0, 64'h1000)),
            // half the address space twice: second one overflows
            write_row(REG_WINDOW_BASE, 64'h0),
            known_row(32'h4, 32'h0, 32'h4, 32'h8000_0000,
                      region(1, 0, 1, 1, 64'h0, 64'h8000_0000_0000_0000)),
            known_row(32'h4, 32'h0, 32'h4, 32'h8000_0000,
                      region(1, 0, 1, 0, 64'h0, 64'h8000_0000_0000_0000)),
            // empty window
            write_row(REG_WINDOW_BASE, 64'h0),
            write_row(REG_WINDOW_LIMIT, 64'h0),
            known_row(32'h0, 32'h0, 32'hFFFF_FFF0, 32'h0, region(1, 0, 0, 0, 64'h0, 64'h10)),
            write_row(REG_WINDOW_ENABLE, 64'h0)
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_results_drained();
                write_window_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                send_probe(directed_rows[i].probe, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            wait_results_drained();
            tx_gap_pct = (ph == 0) ? 21 : (ph == 1) ? 56 : 0;
            rx_stall_pct = (ph == 0) ? 56 : (ph == 1) ? 21 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % REPROGRAM_EVERY == 0) begin
                    wait_results_drained();
                    case ($urandom_range(3))
                        0: base = 64'h0;
                        1: base = {32'h0, $urandom} & ~64'hFFF;
                        2: base = {$urandom, $urandom};
                        default: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 20));
                    endcase
                    case ($urandom_range(5))
                        0: lim = 64'hFFFF_FFFF_FFFF_FFFF;
                        1: lim = {$urandom, $urandom};
                        2: lim = base + 64'($urandom_range(1, 1 << 22));
                        default: lim = base + 64'($urandom_range(1 << 16, 1 << 26));
                    endcase
                    write_window_reg(REG_WINDOW_ENABLE, {63'h0, ($urandom_range(7) != 0)});
                    write_window_reg(REG_WINDOW_BASE, base);
                    write_window_reg(REG_WINDOW_LIMIT, lim);
                end else if ($urandom_range(49) == 0) begin
                    wait_results_drained();
                end
                send_probe(random_probe(), 1'b0, '0);
            end
        end

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> sim.f
rtl/bsp_pkg.sv
rtl/bsp_decode.sv
rtl/bsp_place.sv
rtl/bar_size_and_place.sv
dv/tb_top.sv
